FILE: hw/rtl/chd_pkg.sv
// Shared types, constants and helpers for the compass heading change detector.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package chd_pkg;

   localparam int AxisW    = 16;
   localparam int HeadW    = 12;
   localparam int NumW     = 19;
   localparam int DenW     = 17;
   localparam int AngW     = 16;
   localparam int DivW     = 30;
   localparam int QuoW     = 14;
   localparam int CntW     = 4;
   localparam int StepW    = 3;
   localparam int ScaleW   = 23;
   localparam int ProdW    = AngW + ScaleW;

   localparam int SampleShift = 4;
   localparam int QuarterPiE4 = 7854;
   localparam int PiE4        = 31416;
   localparam int HalfTurn    = 1800;
   localparam int FullTurn    = 2 * HalfTurn;

   // 1800/31416 as 2^27 * 225/3927 rounded up; exact floor for any angle below 31416
   localparam int                ScaleShift = 27;
   localparam logic [ScaleW-1:0] ScaleMul   = ScaleW'(7690092);

   localparam logic [CntW-1:0]  Div1Last = CntW'(QuoW - 1);
   localparam logic [HeadW-1:0] ThresholdReset = HeadW'(FullTurn / 20);

   localparam logic [7:0] AxisLowBad  = 8'h08;
   localparam logic [7:0] AxisHighBad = 8'hF8;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_CAPTURE,
      OP_SETUP,
      OP_DIV_STEP,
      OP_ANGLE,
      OP_SCALE,
      OP_HEAD,
      OP_EMIT
   } chd_op_type;

   typedef struct packed {
      logic item_valid;
      logic sample_bad;
      logic div_last;
      logic slot_busy;
   } chd_stat_type;

   function automatic logic axis_in_range(input logic [AxisW-1:0] v);
      logic [7:0] hi;
      hi = v[AxisW-1:AxisW-8];
      return !(hi >= AxisLowBad && hi < AxisHighBad);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/chd_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
// Depends on chd_pkg for field widths.
`default_nettype none

interface chd_req_if;
   import chd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [AxisW-1:0] x_reading;
   logic signed [AxisW-1:0] y_reading;
   logic signed [AxisW-1:0] z_reading;

   modport source (output valid, output x_reading, output y_reading, output z_reading,
                   input ready);
   modport sink   (input valid, input x_reading, input y_reading, input z_reading,
                   output ready);
endinterface

interface chd_rsp_if;
   import chd_pkg::*;
   logic             valid;
   logic             ready;
   logic             sample_valid;
   logic             heading_changed;
   logic [HeadW-1:0] heading;

   modport source (output valid, output sample_valid, output heading_changed,
                   output heading, input ready);
   modport sink   (input valid, input sample_valid, input heading_changed,
                   input heading, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/chd_seq.sv
// Microcode sequencer: step counter, control ROM and wait/branch logic.
// Depends on chd_pkg for the datapath op codes and status struct.
`default_nettype none

module chd_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  chd_pkg::chd_stat_type stat,
   output chd_pkg::chd_op_type   op
);
   import chd_pkg::*;

   typedef enum logic [1:0] {
      WC_NONE,
      WC_NO_ITEM,
      WC_DIV_BUSY,
      WC_SLOT_BUSY
   } wait_type;

   typedef enum logic [1:0] {
      BC_NONE,
      BC_ALWAYS,
      BC_BAD_SAMPLE
   } branch_type;

   typedef struct packed {
      chd_op_type       op;
      wait_type         wc;
      branch_type       bc;
      logic [StepW-1:0] target;
   } uword_type;

   localparam logic [StepW-1:0] StWait  = StepW'(0);
   localparam logic [StepW-1:0] StSetup = StepW'(1);
   localparam logic [StepW-1:0] StDiv1  = StepW'(2);
   localparam logic [StepW-1:0] StAngle = StepW'(3);
   localparam logic [StepW-1:0] StScale = StepW'(4);
   localparam logic [StepW-1:0] StHead  = StepW'(5);
   localparam logic [StepW-1:0] StEmit  = StepW'(6);

   function automatic uword_type urom(input logic [StepW-1:0] s);
      uword_type w;
      unique case (s)
         StWait:  w = '{OP_CAPTURE,  WC_NO_ITEM,   BC_NONE,       StWait};
         StSetup: w = '{OP_SETUP,    WC_NONE,      BC_BAD_SAMPLE, StEmit};
         StDiv1:  w = '{OP_DIV_STEP, WC_DIV_BUSY,  BC_NONE,       StWait};
         StAngle: w = '{OP_ANGLE,    WC_NONE,      BC_NONE,       StWait};
         StScale: w = '{OP_SCALE,    WC_NONE,      BC_NONE,       StWait};
         StHead:  w = '{OP_HEAD,     WC_NONE,      BC_NONE,       StWait};
         StEmit:  w = '{OP_EMIT,     WC_SLOT_BUSY, BC_ALWAYS,     StWait};
         default: w = '{OP_NOP,      WC_NONE,      BC_ALWAYS,     StWait};
      endcase
      return w;
   endfunction

   uword_type        uw;
   logic             stall;
   logic             take;
   logic [StepW-1:0] pc_ff;
   logic [StepW-1:0] pc_in;

   always_comb begin
      uw = urom(pc_ff);
      unique case (uw.wc)
         WC_NO_ITEM:   stall = !stat.item_valid;
         WC_DIV_BUSY:  stall = !stat.div_last;
         WC_SLOT_BUSY: stall = stat.slot_busy;
         default:      stall = 1'b0;
      endcase
      unique case (uw.bc)
         BC_ALWAYS:     take = 1'b1;
         BC_BAD_SAMPLE: take = stat.sample_bad;
         default:       take = 1'b0;
      endcase
      priority if (stall) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = uw.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= StWait;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign op = uw.op;

endmodule

`default_nettype wire

FILE: hw/rtl/chd_div.sv
// Restoring divider, one quotient bit per cycle while step is high, from a pre-shifted divisor.
// Depends on chd_pkg for operand widths.
`default_nettype none

module chd_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic                      step,
   input  logic [chd_pkg::DivW-1:0]  dividend,
   input  logic [chd_pkg::DivW-1:0]  divisor_shifted,
   input  logic [chd_pkg::CntW-1:0]  last_bit,
   output logic [chd_pkg::QuoW-1:0]  quotient,
   output logic                      last
);
   import chd_pkg::*;

   logic [DivW-1:0] rem_ff;
   logic [DivW-1:0] dsh_ff;
   logic [QuoW-1:0] quo_ff;
   logic [CntW-1:0] cnt_ff;
   logic            fits;

   assign fits = rem_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= last_bit;
      end else if (step) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= dividend;
         dsh_ff <= divisor_shifted;
         quo_ff <= '0;
      end else if (step) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         dsh_ff <= dsh_ff >> 1;
         quo_ff <= {quo_ff[QuoW-2:0], fits};
      end
   end

   assign quotient = quo_ff;
   assign last     = cnt_ff == '0;

endmodule

`default_nettype wire

FILE: hw/rtl/compass_heading_change_detect_core.sv
// Compass heading change detector: range check, fixed-point atan2 heading,
// threshold compare. Uses chd_pkg, chd_if, chd_seq and chd_div.
//
// Usage:
//   req_if carries one magnetometer sample per beat (x, y, z readings).
//   rsp_if returns one beat per sample: sample_valid, heading_changed and
//   the stored heading in tenths of a degree (0..3600).
//   csr_write_enable/csr_write_data write the change threshold; write it
//   only while no sample is in flight. Reset value is 180.
// Sequence:
//   A sample in range passes the setup, serial division, angle, scale and
//   heading steps before it reaches the result register; an out-of-range
//   sample goes from setup straight to the result register. A new sample is
//   taken the cycle after the previous one is placed in the result register,
//   so samples do not overlap. The division is serial (14 quotient bits, one
//   per cycle); the scale to tenths of a degree is a single multiply step.
// Reset clears the stored heading to 0, the threshold to 180 and the valid
// flag of the result register. When the receiver stalls, a result waits in
// the result register while the next sample is processed; that sample then
// holds until the register is free.
`default_nettype none

module compass_heading_change_detect_core (
   input  logic                       clock,
   input  logic                       reset,
   chd_req_if.sink                    req_if,
   chd_rsp_if.source                  rsp_if,
   input  logic                       csr_write_enable,
   input  logic [chd_pkg::HeadW-1:0]  csr_write_data
);
   import chd_pkg::*;

   localparam logic signed [NumW-1:0] BaseLow  = NumW'(QuarterPiE4);
   localparam logic signed [NumW-1:0] BaseHigh = NumW'(3 * QuarterPiE4);

   chd_op_type   op;
   chd_stat_type stat;

   logic signed [AxisW-1:0] x_ff;
   logic signed [AxisW-1:0] y_ff;
   logic                    sample_ok_ff;
   logic                    pnonneg_ff;
   logic                    numneg_ff;
   logic                    changed_ff;
   logic [AngW-1:0]         ang_ff;
   logic [HeadW-1:0]        q2_ff;
   logic [HeadW-1:0]        last_heading_ff;
   logic [HeadW-1:0]        threshold_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_sample_valid_ff;
   logic                    rsp_changed_ff;
   logic [HeadW-1:0]        rsp_heading_ff;

   logic signed [NumW-1:0] x_ext;
   logic signed [NumW-1:0] p_ext;
   logic signed [NumW-1:0] big_p;
   logic signed [NumW-1:0] big_q;
   logic signed [NumW-1:0] abs_q;
   logic signed [NumW-1:0] m_val;
   logic signed [NumW-1:0] num_val;
   logic signed [NumW-1:0] den_val;
   logic signed [NumW-1:0] abs_num;
   logic                   pnonneg;
   logic [DivW-1:0]        prod1;

   logic signed [NumW-1:0] sq;
   logic signed [NumW-1:0] a0;
   logic [ProdW-1:0]       scale_prod;

   logic [HeadW-1:0]       h_val;
   logic [HeadW:0]         diff;
   logic [HeadW:0]         abs_diff;
   logic                   hit;

   logic                   slot_free;
   logic                   div_load;
   logic                   div_step;
   logic [DivW-1:0]        div_dividend;
   logic [DivW-1:0]        div_divisor;
   logic [CntW-1:0]        div_last_bit;
   logic [QuoW-1:0]        quotient;
   logic                   div_last;

   // setup: operands of the first division
   always_comb begin
      x_ext   = NumW'(x_ff);
      p_ext   = -NumW'(y_ff);
      pnonneg = !p_ext[NumW-1];
      big_p   = p_ext <<< SampleShift;
      big_q   = x_ext <<< SampleShift;
      abs_q   = big_q[NumW-1] ? -big_q : big_q;
      m_val   = abs_q + NumW'(1);
      num_val = pnonneg ? (big_p - m_val) : (m_val + big_p);
      den_val = pnonneg ? (big_p + m_val) : (m_val - big_p);
      abs_num = num_val[NumW-1] ? -num_val : num_val;
      prod1   = DivW'(abs_num[DenW-1:0]) * DivW'(QuarterPiE4);
   end

   // angle: signed first quotient, then scale to tenths of a degree
   always_comb begin
      sq         = numneg_ff ? -NumW'(quotient) : NumW'(quotient);
      a0         = (pnonneg_ff ? BaseLow : BaseHigh) - sq;
      scale_prod = ProdW'(ang_ff) * ProdW'(ScaleMul);
   end

   // heading and threshold compare
   always_comb begin
      h_val    = x_ff[AxisW-1] ? (HeadW'(HalfTurn) - q2_ff) : (HeadW'(HalfTurn) + q2_ff);
      diff     = {1'b0, h_val} - {1'b0, last_heading_ff};
      abs_diff = diff[HeadW] ? -diff : diff;
      hit      = abs_diff[HeadW-1:0] >= threshold_ff;
   end

   assign div_load     = op == OP_SETUP;
   assign div_step     = op == OP_DIV_STEP;
   assign div_dividend = prod1;
   assign div_divisor  = DivW'(den_val[DenW-1:0]) << Div1Last;
   assign div_last_bit = Div1Last;

   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   assign stat.item_valid = req_if.valid;
   assign stat.sample_bad = !sample_ok_ff;
   assign stat.div_last   = div_last;
   assign stat.slot_busy  = !slot_free;

   chd_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .op    (op)
   );

   chd_div u_div (
      .clock           (clock),
      .reset           (reset),
      .load            (div_load),
      .step            (div_step),
      .dividend        (div_dividend),
      .divisor_shifted (div_divisor),
      .last_bit        (div_last_bit),
      .quotient        (quotient),
      .last            (div_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= ThresholdReset;
         last_heading_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            threshold_ff <= csr_write_data;
         end
         if (op == OP_HEAD && hit) begin
            last_heading_ff <= h_val;
         end
         if (op == OP_EMIT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op == OP_CAPTURE && req_if.valid) begin
         x_ff         <= req_if.x_reading;
         y_ff         <= req_if.y_reading;
         sample_ok_ff <= axis_in_range(req_if.x_reading) &&
                         axis_in_range(req_if.y_reading) &&
                         axis_in_range(req_if.z_reading);
      end
      if (op == OP_SETUP) begin
         pnonneg_ff <= pnonneg;
         numneg_ff  <= num_val[NumW-1];
         changed_ff <= 1'b0;
      end
      if (op == OP_ANGLE) begin
         ang_ff <= a0[AngW-1:0];
      end
      if (op == OP_SCALE) begin
         q2_ff <= scale_prod[ScaleShift +: HeadW];
      end
      if (op == OP_HEAD) begin
         changed_ff <= hit;
      end
      if (op == OP_EMIT && slot_free) begin
         rsp_sample_valid_ff <= sample_ok_ff;
         rsp_changed_ff      <= changed_ff;
         rsp_heading_ff      <= last_heading_ff;
      end
   end

   assign req_if.ready           = op == OP_CAPTURE;
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.sample_valid    = rsp_sample_valid_ff;
   assign rsp_if.heading_changed = rsp_changed_ff;
   assign rsp_if.heading         = rsp_heading_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/chd_check.sv
// Port-level checks on the result channel of the heading change detector,
// bound to compass_heading_change_detect_core. Depends on chd_pkg.
`default_nettype none

module chd_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       sample_valid,
   input logic                       heading_changed,
   input logic [chd_pkg::HeadW-1:0]  heading
);
   import chd_pkg::*;

   logic             beat;
   logic [HeadW-1:0] seen_heading_ff;

   assign beat = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_heading_ff <= '0;
      end else if (beat) begin
         seen_heading_ff <= heading;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(heading) &&
         $stable(heading_changed) && $stable(sample_valid))
      else $error("result beat changed while stalled");

   a_bad_no_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !sample_valid |-> !heading_changed)
      else $error("change reported for an out-of-range sample");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> heading <= HeadW'(FullTurn))
      else $error("heading above full turn");

   a_heading_kept: assert property (@(posedge clock) disable iff (reset)
      beat && !heading_changed |-> heading == seen_heading_ff)
      else $error("stored heading moved without a reported change");

endmodule

bind compass_heading_change_detect_core chd_check u_chd_check (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .sample_valid    (rsp_if.sample_valid),
   .heading_changed (rsp_if.heading_changed),
   .heading         (rsp_if.heading)
);

`default_nettype wire
